/* rtl/bsrs_pkg.sv */
// bsrs_pkg: shared types, codes and constants of the bitmap slot record store
// used by the top, datapath and controller; no dependencies
`timescale 1ns / 1ps

package bsrs_pkg;

  localparam int SECTOR_BYTES_DEF     = 4096;
  localparam int MAX_RECORD_BYTES_DEF = 64;
  localparam int RS_W                 = 7;
  localparam logic [RS_W-1:0] RS_RESET = 7'd16;
  localparam logic [7:0] ERASED_BYTE  = 8'hFF;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    STAT_WRITTEN = 2'd0,
    STAT_SKIPPED = 2'd1,
    STAT_READ    = 2'd2,
    STAT_FAIL    = 2'd3
  } stat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_STAGE,
    OP_STG_RESET,
    OP_DIV1_GO,
    OP_FB_LOAD,
    OP_DIV2_GO,
    OP_PARTS_LOAD,
    OP_HDR_RD0,
    OP_HDR_RD1,
    OP_CNT_CLR,
    OP_CLR_STEP,
    OP_ERASE_STEP,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_IDX_ZERO,
    OP_RIDX_FOUND,
    OP_RIDX_LAST,
    OP_OFF_PREV,
    OP_OFF_CUR,
    OP_CMP_RD,
    OP_CMP_STEP,
    OP_BM_WR,
    OP_CP_RD,
    OP_CP_WR,
    OP_EM_RD,
    OP_EM_PUSH,
    OP_PUSH_STAT
  } op_t;

  typedef struct packed {
    op_t   op;
    stat_t stat;
  } dp_cmd_t;

  typedef struct packed {
    logic rs_valid;
    logic stage_full;
    logic div_done;
    logic parts_zero;
    logic hdr_ok;
    logic cnt_last;
    logic scan_nz;
    logic scan_end;
    logic idx_zero;
    logic idx_ge_parts;
    logic off_bad;
    logic cmp_eq;
    logic k_last;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_HDR0,
    ST_HDR1,
    ST_HDR_CHK,
    ST_ERASE,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FOUND,
    ST_IDX0,
    ST_OFFP,
    ST_CMP_CHK0,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_WOFF,
    ST_WCHK,
    ST_CP_RD,
    ST_CP_WR,
    ST_RIDX,
    ST_RCHK,
    ST_ROFF_CHK,
    ST_EM_RD,
    ST_EM_OUT,
    ST_FAIL,
    ST_SKIP,
    ST_OK
  } state_t;

endpackage

/* rtl/bitmap_slot_record_store.sv */
// a staged byte that does not complete a record only fills the staging buffer; a commit
// runs the geometry division, scans the bitmap, compares and copies record bytes, and
// erases the sector when needed; a read returns the newest record byte by byte
// one request is in flight at a time
// reset: synchronous, active low; afterwards a clearing pass writes 0xFF over the
// sector memory, and in_ready stays low until it ends
`timescale 1ns / 1ps

module bitmap_slot_record_store
  import bsrs_pkg::*;
#(
  parameter int SECTOR_BYTES     = SECTOR_BYTES_DEF,
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  // request channel: stage one byte or read the newest record
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  // result channel, one result per transfer
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  // record size register write
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [RS_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: walks the commit and read flows, one step per state
  bsrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: sector memory, staging memory, divider, pointers, output register
  bsrs_datapath #(
    .SECTOR_BYTES     (SECTOR_BYTES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/bsrs_ram.sv */
// bsrs_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module bsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bsrs_div.sv */
// bsrs_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module bsrs_div #(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, den_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

/* rtl/bsrs_datapath.sv */
// bsrs_datapath: sector image, staging buffer, geometry divider, pointers and
// output register; depends on bsrs_pkg, bsrs_ram, bsrs_div
`timescale 1ns / 1ps

module bsrs_datapath
  import bsrs_pkg::*;
#(
  parameter int SECTOR_BYTES     = SECTOR_BYTES_DEF,
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  output dp_sts_t         sts,
  input  in_item_t        in_data,
  input  logic            cfg_valid,
  input  logic [RS_W-1:0] cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data
);

  localparam int AW  = $clog2(SECTOR_BYTES);
  localparam int NW  = AW + 3;
  localparam int OW  = NW + 8;
  localparam int SAW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

  logic [RS_W-1:0] rs_r, rs_nxt;
  logic [RS_W-1:0] staged_r, staged_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [RS_W-1:0] k_r, k_nxt;
  logic [NW-1:0]   fb_r, fb_nxt;
  logic [NW-1:0]   parts_r, parts_nxt;
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [7:0]      bm_r, bm_nxt;
  logic [OW-1:0]   off_r, off_nxt;
  logic            hdr0_ok_r, hdr0_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            sec_we, sec_re;
  logic [AW-1:0]   sec_waddr, sec_raddr;
  logic [7:0]      sec_wdata, sec_rdata;
  logic            stg_we, stg_re;
  logic [SAW-1:0]  stg_waddr, stg_raddr;
  logic [7:0]      stg_rdata;

  logic            div_start, div_done;
  logic [NW-1:0]   div_num, div_den, div_quo;

  logic [RS_W-1:0] stage_base, stage_new;
  logic [NW-1:0]   fb_calc, idx_mul;
  logic [OW-1:0]   off_calc;
  logic [AW-1:0]   off_addr;
  logic            parts_zero, rs_valid, k_last, out_free;

  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        p = 3'(i);
      end
    end
    return p;
  endfunction

  bsrs_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_sector (
    .clk(clk), .we(sec_we), .waddr(sec_waddr), .wdata(sec_wdata),
    .re(sec_re), .raddr(sec_raddr), .rdata(sec_rdata)
  );

  bsrs_ram #(.WIDTH(8), .DEPTH(MAX_RECORD_BYTES)) u_staging (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(in_data.data_byte),
    .re(stg_re), .raddr(stg_raddr), .rdata(stg_rdata)
  );

  bsrs_div #(.W(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .done(div_done)
  );

  // geometry helpers
  assign rs_valid   = (rs_r != '0) && (32'(rs_r) <= MAX_RECORD_BYTES);
  assign stage_base = (staged_r >= rs_r) ? '0 : staged_r;
  assign stage_new  = stage_base + RS_W'(1);
  assign fb_calc    = ((div_quo + NW'(31)) >> 5) << 2;
  assign parts_zero = (fb_r + NW'(2)) >= NW'(SECTOR_BYTES);
  assign k_last     = (k_r + RS_W'(1)) == rs_r;
  assign out_free   = !out_valid_r || out_ready;
  assign off_addr   = AW'(off_r + OW'(k_r));
  assign idx_mul    = (cmd.op == OP_OFF_PREV) ? (idx_r - NW'(1)) : idx_r;
  assign off_calc   = OW'(2) + OW'(fb_r) + OW'(idx_mul) * OW'(rs_r);

  always_comb begin
    rs_nxt        = rs_r;
    staged_nxt    = staged_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    fb_nxt        = fb_r;
    parts_nxt     = parts_r;
    idx_nxt       = idx_r;
    bm_nxt        = bm_r;
    off_nxt       = off_r;
    hdr0_ok_nxt   = hdr0_ok_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sec_we        = 1'b0;
    sec_waddr     = cnt_r;
    sec_wdata     = ERASED_BYTE;
    sec_re        = 1'b0;
    sec_raddr     = off_addr;
    stg_we        = 1'b0;
    stg_waddr     = stage_base[SAW-1:0];
    stg_re        = 1'b0;
    stg_raddr     = k_r[SAW-1:0];
    div_start     = 1'b0;
    div_num       = NW'((SECTOR_BYTES - 2) * 8);
    div_den       = NW'({rs_r, 3'b001});

    case (cmd.op)
      OP_STAGE: begin
        stg_we     = 1'b1;
        staged_nxt = (stage_new == rs_r) ? '0 : stage_new;
      end
      OP_STG_RESET: begin
        staged_nxt = '0;
      end
      OP_DIV1_GO: begin
        div_start = 1'b1;
      end
      OP_FB_LOAD: begin
        fb_nxt = fb_calc;
      end
      OP_DIV2_GO: begin
        div_start = 1'b1;
        div_num   = parts_zero ? '0 : (NW'(SECTOR_BYTES - 2) - fb_r);
        div_den   = NW'(rs_r);
      end
      OP_PARTS_LOAD: begin
        parts_nxt = parts_zero ? '0 : div_quo;
      end
      OP_HDR_RD0: begin
        sec_re    = 1'b1;
        sec_raddr = '0;
      end
      OP_HDR_RD1: begin
        sec_re      = 1'b1;
        sec_raddr   = AW'(1);
        hdr0_ok_nxt = sec_rdata == {1'b0, rs_r};
      end
      OP_CNT_CLR: begin
        cnt_nxt = '0;
        k_nxt   = '0;
      end
      OP_CLR_STEP: begin
        sec_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
      end
      OP_ERASE_STEP: begin
        sec_we = 1'b1;
        if (cnt_r == '0) begin
          sec_wdata = {1'b0, rs_r};
        end else if (cnt_r == AW'(1)) begin
          sec_wdata = 8'h00;
        end
        cnt_nxt = cnt_r + AW'(1);
      end
      OP_SCAN_RD: begin
        sec_re    = 1'b1;
        sec_raddr = AW'(2) + cnt_r;
      end
      OP_SCAN_CHK: begin
        if (sec_rdata != 8'h00) begin
          idx_nxt = (NW'(cnt_r) << 3) | NW'(low_bit(sec_rdata));
          bm_nxt  = sec_rdata;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      OP_IDX_ZERO: begin
        idx_nxt = '0;
        bm_nxt  = ERASED_BYTE;
      end
      OP_RIDX_FOUND: begin
        idx_nxt = idx_r - NW'(1);
      end
      OP_RIDX_LAST: begin
        idx_nxt = (fb_r << 3) - NW'(1);
      end
      OP_OFF_PREV, OP_OFF_CUR: begin
        off_nxt = off_calc;
      end
      OP_CMP_RD: begin
        sec_re = 1'b1;
        stg_re = 1'b1;
      end
      OP_CMP_STEP: begin
        k_nxt = k_r + RS_W'(1);
      end
      OP_BM_WR: begin
        sec_we    = 1'b1;
        sec_waddr = AW'(2) + AW'(idx_r >> 3);
        sec_wdata = bm_r & ~(8'h01 << idx_r[2:0]);
        k_nxt     = '0;
      end
      OP_CP_RD: begin
        stg_re = 1'b1;
      end
      OP_CP_WR: begin
        sec_we    = 1'b1;
        sec_waddr = off_addr;
        sec_wdata = stg_rdata;
        k_nxt     = k_r + RS_W'(1);
      end
      OP_EM_RD: begin
        sec_re = 1'b1;
      end
      OP_EM_PUSH: begin
        out_valid_nxt   = 1'b1;
        out_nxt.out_byte = sec_rdata;
        out_nxt.status  = STAT_READ;
        out_nxt.last    = k_last;
        k_nxt           = k_r + RS_W'(1);
      end
      OP_PUSH_STAT: begin
        out_valid_nxt   = 1'b1;
        out_nxt.out_byte = 8'h00;
        out_nxt.status  = cmd.stat;
        out_nxt.last    = 1'b1;
      end
      default: begin
      end
    endcase

    // register write drops any partial record
    if (cfg_valid) begin
      rs_nxt     = cfg_data;
      staged_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r        <= RS_RESET;
      staged_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rs_r        <= rs_nxt;
      staged_r    <= staged_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r       <= k_nxt;
    fb_r      <= fb_nxt;
    parts_r   <= parts_nxt;
    idx_r     <= idx_nxt;
    bm_r      <= bm_nxt;
    off_r     <= off_nxt;
    hdr0_ok_r <= hdr0_ok_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    sts.rs_valid     = rs_valid;
    sts.stage_full   = stage_new == rs_r;
    sts.div_done     = div_done;
    sts.parts_zero   = parts_r == '0;
    sts.hdr_ok       = hdr0_ok_r && (sec_rdata == 8'h00);
    sts.cnt_last     = cnt_r == AW'(SECTOR_BYTES - 1);
    sts.scan_nz      = sec_rdata != 8'h00;
    sts.scan_end     = (NW'(cnt_r) + NW'(1)) >= fb_r;
    sts.idx_zero     = idx_r == '0;
    sts.idx_ge_parts = idx_r >= parts_r;
    sts.off_bad      = (off_r + OW'(rs_r)) > OW'(SECTOR_BYTES);
    sts.cmp_eq       = sec_rdata == stg_rdata;
    sts.k_last       = k_last;
    sts.out_free     = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/bsrs_ctrl.sv */
// bsrs_ctrl: sequencer for staging, commit, read and erase sweeps
// depends on bsrs_pkg
`timescale 1ns / 1ps

module bsrs_ctrl
  import bsrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   is_read_r, is_read_nxt;
  logic   to_scan_r, to_scan_nxt;

  // next state
  always_comb begin
    state_nxt   = state_r;
    is_read_nxt = is_read_r;
    to_scan_nxt = to_scan_r;
    case (state_r)
      ST_CLEAR:     if (sts.cnt_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          is_read_nxt = in_kind == KIND_READ;
          if (!sts.rs_valid) begin
            state_nxt = ST_FAIL;
          end else if (in_kind == KIND_READ || sts.stage_full) begin
            state_nxt = ST_DIV1_GO;
          end
        end
      end
      ST_DIV1_GO:   state_nxt = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (sts.div_done) state_nxt = ST_DIV2_GO;
      ST_DIV2_GO:   state_nxt = ST_DIV2_WAIT;
      ST_DIV2_WAIT: if (sts.div_done) state_nxt = ST_HDR0;
      ST_HDR0:      state_nxt = ST_HDR1;
      ST_HDR1:      state_nxt = ST_HDR_CHK;
      ST_HDR_CHK: begin
        if (sts.parts_zero || (is_read_r && !sts.hdr_ok)) begin
          state_nxt = ST_FAIL;
        end else if (!sts.hdr_ok) begin
          to_scan_nxt = 1'b1;
          state_nxt   = ST_ERASE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_ERASE: begin
        if (sts.cnt_last) begin
          state_nxt = to_scan_r ? ST_SCAN_INIT : ST_IDX0;
        end
      end
      ST_SCAN_INIT: state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:   state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (sts.scan_nz) begin
          state_nxt = is_read_r ? ST_RIDX : ST_FOUND;
        end else if (sts.scan_end) begin
          if (is_read_r) begin
            state_nxt = ST_RCHK;
          end else begin
            to_scan_nxt = 1'b0;
            state_nxt   = ST_ERASE;
          end
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_FOUND: begin
        if (sts.idx_ge_parts) begin
          to_scan_nxt = 1'b0;
          state_nxt   = ST_ERASE;
        end else if (sts.idx_zero) begin
          state_nxt = ST_WOFF;
        end else begin
          state_nxt = ST_OFFP;
        end
      end
      ST_IDX0:      state_nxt = ST_WOFF;
      ST_OFFP:      state_nxt = ST_CMP_CHK0;
      ST_CMP_CHK0:  state_nxt = sts.off_bad ? ST_WOFF : ST_CMP_RD;
      ST_CMP_RD:    state_nxt = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (!sts.cmp_eq) begin
          state_nxt = ST_WOFF;
        end else if (sts.k_last) begin
          state_nxt = ST_SKIP;
        end else begin
          state_nxt = ST_CMP_RD;
        end
      end
      ST_WOFF:      state_nxt = ST_WCHK;
      ST_WCHK:      state_nxt = sts.off_bad ? ST_FAIL : ST_CP_RD;
      ST_CP_RD:     state_nxt = ST_CP_WR;
      ST_CP_WR:     state_nxt = sts.k_last ? ST_OK : ST_CP_RD;
      ST_RIDX:      state_nxt = sts.idx_zero ? ST_FAIL : ST_RCHK;
      ST_RCHK:      state_nxt = sts.idx_ge_parts ? ST_FAIL : ST_ROFF_CHK;
      ST_ROFF_CHK:  state_nxt = sts.off_bad ? ST_FAIL : ST_EM_RD;
      ST_EM_RD:     state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.k_last ? ST_IDLE : ST_EM_RD;
        end
      end
      ST_FAIL, ST_SKIP, ST_OK: if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.stat = STAT_FAIL;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:     cmd.op = OP_CLR_STEP;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_kind == KIND_WRITE) begin
          cmd.op = sts.rs_valid ? OP_STAGE : OP_STG_RESET;
        end
      end
      ST_DIV1_GO:   cmd.op = OP_DIV1_GO;
      ST_DIV1_WAIT: if (sts.div_done) cmd.op = OP_FB_LOAD;
      ST_DIV2_GO:   cmd.op = OP_DIV2_GO;
      ST_DIV2_WAIT: if (sts.div_done) cmd.op = OP_PARTS_LOAD;
      ST_HDR0:      cmd.op = OP_HDR_RD0;
      ST_HDR1:      cmd.op = OP_HDR_RD1;
      ST_HDR_CHK:   cmd.op = OP_CNT_CLR;
      ST_ERASE:     cmd.op = OP_ERASE_STEP;
      ST_SCAN_INIT: cmd.op = OP_CNT_CLR;
      ST_SCAN_RD:   cmd.op = OP_SCAN_RD;
      ST_SCAN_CHK: begin
        if (sts.scan_nz) begin
          cmd.op = OP_SCAN_CHK;
        end else if (sts.scan_end) begin
          cmd.op = is_read_r ? OP_RIDX_LAST : OP_CNT_CLR;
        end else begin
          cmd.op = OP_SCAN_CHK;
        end
      end
      ST_FOUND:     if (sts.idx_ge_parts) cmd.op = OP_CNT_CLR;
      ST_IDX0:      cmd.op = OP_IDX_ZERO;
      ST_OFFP:      cmd.op = OP_OFF_PREV;
      ST_CMP_CHK0:  cmd.op = OP_CNT_CLR;
      ST_CMP_RD:    cmd.op = OP_CMP_RD;
      ST_CMP_CHK:   if (sts.cmp_eq && !sts.k_last) cmd.op = OP_CMP_STEP;
      ST_WOFF:      cmd.op = OP_OFF_CUR;
      ST_WCHK:      if (!sts.off_bad) cmd.op = OP_BM_WR;
      ST_CP_RD:     cmd.op = OP_CP_RD;
      ST_CP_WR:     cmd.op = OP_CP_WR;
      ST_RIDX:      if (!sts.idx_zero) cmd.op = OP_RIDX_FOUND;
      ST_RCHK:      cmd.op = OP_OFF_CUR;
      ST_ROFF_CHK:  cmd.op = OP_CNT_CLR;
      ST_EM_RD:     cmd.op = OP_EM_RD;
      ST_EM_OUT:    if (sts.out_free) cmd.op = OP_EM_PUSH;
      ST_FAIL: begin
        cmd.stat = STAT_FAIL;
        if (sts.out_free) cmd.op = OP_PUSH_STAT;
      end
      ST_SKIP: begin
        cmd.stat = STAT_SKIPPED;
        if (sts.out_free) cmd.op = OP_PUSH_STAT;
      end
      ST_OK: begin
        cmd.stat = STAT_WRITTEN;
        if (sts.out_free) cmd.op = OP_PUSH_STAT;
      end
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      is_read_r <= 1'b0;
      to_scan_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      is_read_r <= is_read_nxt;
      to_scan_r <= to_scan_nxt;
    end
  end

endmodule

/* dv/tb.sv */
// tb: self-checking testbench of bitmap_slot_record_store, with its own sector model
// depends on rtl/bsrs_pkg.sv and rtl/bitmap_slot_record_store.sv
`timescale 1ns / 1ps

module tb;
  import bsrs_pkg::*;

  localparam int SECT     = SECTOR_BYTES_DEF;
  localparam int MAXREC   = MAX_RECORD_BYTES_DEF;
  localparam int HDR      = 2;
  // no-transfer cycles: clearing pass or erase plus a full-record compare, many times over
  localparam int QUIET_LIMIT = 40000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [RS_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  bitmap_slot_record_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- sector model
  logic [7:0]      sector_mem [SECT];
  logic [7:0]      stage_mem [MAXREC];
  int unsigned     stage_cnt;
  logic [RS_W-1:0] rec_size;
  out_item_t       pending_results [$];
  int              errors = 0;
  bit              quiet = 1'b0;   // phase with no idling on either side

  function automatic int unsigned bitmap_len(int unsigned rs);
    return (((SECT - HDR) * 8) / (rs * 8 + 1) + 31) / 32 * 4;
  endfunction

  function automatic int unsigned slot_count(int unsigned rs, int unsigned fb);
    if (fb + HDR >= SECT) return 0;
    return (SECT - HDR - fb) / rs;
  endfunction

  function automatic void erase_sector(int unsigned rs);
    for (int i = 0; i < SECT; i++) sector_mem[i] = ERASED_BYTE;
    sector_mem[0] = rs[7:0];
    sector_mem[1] = rs[15:8];
  endfunction

  function automatic int unsigned header_of();
    return {sector_mem[1], sector_mem[0]};
  endfunction

  // lowest set bitmap bit, -1 when every slot is used
  function automatic int lowest_free(int unsigned fb);
    for (int b = 0; b < fb; b++)
      for (int i = 0; i < 8; i++)
        if (sector_mem[HDR + b][i]) return b * 8 + i;
    return -1;
  endfunction

  function automatic stat_t commit_record(int unsigned rs);
    int unsigned fb, parts, off;
    int          idx;
    bit          same;
    fb = bitmap_len(rs);
    parts = slot_count(rs, fb);
    if (parts == 0) return STAT_FAIL;
    if (header_of() != rs) erase_sector(rs);
    idx = lowest_free(fb);
    if (idx < 0 || idx >= parts) begin
      erase_sector(rs);
      idx = 0;
    end
    if (idx > 0) begin
      off = HDR + fb + (idx - 1) * rs;
      if (off + rs <= SECT) begin
        same = 1'b1;
        for (int k = 0; k < rs; k++)
          if (sector_mem[off + k] != stage_mem[k]) same = 1'b0;
        if (same) return STAT_SKIPPED;
      end
    end
    off = HDR + fb + idx * rs;
    if (off + rs > SECT) return STAT_FAIL;
    sector_mem[HDR + idx / 8][idx % 8] = 1'b0;
    for (int k = 0; k < rs; k++) sector_mem[off + k] = stage_mem[k];
    return STAT_WRITTEN;
  endfunction

  function automatic void push_result(logic [7:0] b, stat_t st, logic lst);
    out_item_t r;
    r.out_byte = b;
    r.status = st;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void read_newest(int unsigned rs);
    int unsigned fb, parts, off;
    int          p, idx;
    fb = bitmap_len(rs);
    parts = slot_count(rs, fb);
    p = lowest_free(fb);
    idx = (p < 0) ? fb * 8 - 1 : p - 1;
    off = HDR + fb + idx * rs;
    if (header_of() != rs || parts == 0 || p == 0 || idx >= parts || off + rs > SECT) begin
      push_result(8'h00, STAT_FAIL, 1'b1);
    end else begin
      for (int k = 0; k < rs; k++)
        push_result(sector_mem[off + k], STAT_READ, k == rs - 1);
    end
  endfunction

  // works out the results of one accepted request
  function automatic void model_request(in_item_t it);
    int unsigned rs;
    rs = rec_size;
    if (rs == 0 || rs > MAXREC) begin
      if (it.kind == KIND_WRITE) stage_cnt = 0;
      push_result(8'h00, STAT_FAIL, 1'b1);
    end else if (it.kind == KIND_READ) begin
      read_newest(rs);
    end else begin
      if (stage_cnt >= rs) stage_cnt = 0;
      stage_mem[stage_cnt] = it.data_byte;
      stage_cnt++;
      if (stage_cnt == rs) begin
        stage_cnt = 0;
        push_result(8'h00, commit_record(rs), 1'b1);
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------- result side
  // receiver stalls at random after each transfer, except in a quiet phase
  int out_stall = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_stall = quiet ? 0 : $urandom_range(0, 10);
    end else if (out_stall > 0) begin
      out_stall--;
    end
    out_ready <= rst_n && out_stall == 0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        e = pending_results.pop_front();
        if (out_data.out_byte !== e.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_data.out_byte, e.out_byte));
        if (out_data.status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, e.status));
        if (out_data.last !== e.last)
          report_mismatch($sformatf("last %b, want %b", out_data.last, e.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- request side
  task automatic send_request(logic kind, logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, data_byte: b};
    do @(posedge clk); while (!in_ready);
    model_request('{kind: kind, data_byte: b});
  endtask

  // drop valid and wait until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);   // a staged byte finishes with no result
  endtask

  task automatic write_record_size(logic [RS_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rec_size = v;
    stage_cnt = 0;
  endtask

  // directed rows: a size write, or a request with an optional typed-in status
  typedef struct packed {
    logic            is_cfg;
    logic [RS_W-1:0] size;
    logic            kind;
    logic [7:0]      data_byte;
    logic            typed;
    stat_t           want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic dir_row_t req_row(logic kind, logic [7:0] b, logic typed, stat_t want);
    return '{is_cfg: 1'b0, size: '0, kind: kind, data_byte: b, typed: typed, want: want};
  endfunction

  function automatic dir_row_t cfg_row(logic [RS_W-1:0] v);
    return '{is_cfg: 1'b1, size: v, kind: KIND_WRITE, data_byte: '0, typed: 1'b0,
             want: STAT_WRITTEN};
  endfunction

  logic [7:0] prev_rec [MAXREC];

  // one record of random content, or a copy of the previous one to hit the skip path
  task automatic send_record(int unsigned rs, bit allow_copy);
    bit copy;
    copy = allow_copy && ($urandom_range(0, 9) < 4);
    for (int k = 0; k < rs; k++) begin
      if (!copy) prev_rec[k] = 8'($urandom_range(0, 255));
      send_request(KIND_WRITE, prev_rec[k]);
    end
  endtask

  initial begin
    logic [RS_W-1:0] sizes [$];
    int              sent;
    int unsigned     rs;
    for (int i = 0; i < SECT; i++) sector_mem[i] = ERASED_BYTE;
    for (int i = 0; i < MAXREC; i++) stage_mem[i] = 8'h00;
    stage_cnt = 0;
    rec_size = RS_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: erased sector, extreme bytes, header change, skip, bad size
    dir_rows.push_back(req_row(KIND_READ, 8'hFF, 1'b1, STAT_FAIL));
    for (int k = 0; k < 16; k++)
      dir_rows.push_back(req_row(KIND_WRITE, k[0] ? 8'hFF : 8'h00, k == 15, STAT_WRITTEN));
    dir_rows.push_back(req_row(KIND_READ, 8'h00, 1'b0, STAT_READ));
    dir_rows.push_back(cfg_row(7'd2));
    dir_rows.push_back(req_row(KIND_READ, 8'h00, 1'b1, STAT_FAIL));
    dir_rows.push_back(req_row(KIND_WRITE, 8'hA5, 1'b0, STAT_WRITTEN));
    dir_rows.push_back(req_row(KIND_WRITE, 8'h5A, 1'b1, STAT_WRITTEN));
    dir_rows.push_back(req_row(KIND_WRITE, 8'hA5, 1'b0, STAT_WRITTEN));
    dir_rows.push_back(req_row(KIND_WRITE, 8'h5A, 1'b1, STAT_SKIPPED));
    dir_rows.push_back(req_row(KIND_READ, 8'hFF, 1'b0, STAT_READ));
    dir_rows.push_back(cfg_row(7'd0));
    dir_rows.push_back(req_row(KIND_WRITE, 8'h3C, 1'b1, STAT_FAIL));
    dir_rows.push_back(req_row(KIND_READ, 8'h00, 1'b1, STAT_FAIL));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_record_size(dir_rows[i].size);
      end else begin
        send_request(dir_rows[i].kind, dir_rows[i].data_byte);
        // typed rows cause exactly one result; take the table's status over the model's
        if (dir_rows[i].typed)
          pending_results[pending_results.size() - 1] = '{8'h00, dir_rows[i].want, 1'b1};
      end
    end

    // random phases: extremes of the size, both invalid sizes, some random ones
    sizes = '{7'd1, 7'd64, 7'd127, 7'd7, 7'd0, 7'd16};
    repeat (3) sizes.push_back(7'($urandom_range(1, 12)));
    foreach (sizes[i]) begin
      write_record_size(sizes[i]);
      quiet = ($urandom_range(0, 3) == 0);
      rs = sizes[i];
      sent = 0;
      while (sent < 14) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            send_request(KIND_READ, 8'($urandom_range(0, 255)));
            sent++;
          end
          2: begin
            // stray byte, which may leave a partial record for the next size write to drop
            send_request(KIND_WRITE, 8'($urandom_range(0, 255)));
            sent++;
          end
          default: begin
            if (rs == 0 || rs > MAXREC) begin
              send_request(KIND_WRITE, 8'($urandom_range(0, 255)));
              sent++;
            end else begin
              send_record(rs, 1'b1);
              sent += rs;
            end
          end
        endcase
      end
    end
    quiet = 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bsrs_pkg.sv
rtl/bsrs_ram.sv
rtl/bsrs_div.sv
rtl/bsrs_datapath.sv
rtl/bsrs_ctrl.sv
rtl/bitmap_slot_record_store.sv
dv/tb.sv
